/* hdl/mandelbrot_escape_time_pixel_core_macros.svh */
// Assertion macros shared by the escape-time pixel core.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define MBE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mbe_pkg.sv */
// Shared constants, types and fixed-point helpers of the escape-time pixel core.
`default_nettype none
package mbe_pkg;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 24;
	localparam int COORD_USE  = (COORD_BITS < 12) ? COORD_BITS : 12;
	localparam int DIV_STAGES = 8;

	localparam logic signed [31:0] X_MIN_RST  = 32'(-(64'sd2 <<< FRAC_BITS));
	localparam logic signed [31:0] Y_MIN_RST  = 32'(-(64'sd2 <<< FRAC_BITS));
	localparam logic signed [31:0] STEP_X_RST = 32'sd62915;
	localparam logic signed [31:0] STEP_Y_RST = 32'sd83886;
	localparam logic [7:0]         MAX_IT_RST = 8'd40;
	localparam logic signed [31:0] FOUR       = 32'(64'sd4 <<< FRAC_BITS);

	typedef enum logic [2:0] {
		REG_X_MIN    = 3'd0,
		REG_Y_MIN    = 3'd1,
		REG_STEP_X   = 3'd2,
		REG_STEP_Y   = 3'd3,
		REG_MAX_ITER = 3'd4
	} cfg_reg_t;

	// One word moving down the gray-level divider chain.
	typedef struct packed {
		logic        valid;
		logic [15:0] rem;
		logic [7:0]  div;
		logic [7:0]  quo;
		logic [7:0]  iters;
		logic        esc;
	} div_word_t;

	function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Fixed-point product, floored and saturated.
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] prod;
		prod = ext64(a) * ext64(b);
		return sat32(prod >>> FRAC_BITS);
	endfunction
endpackage
`default_nettype wire

/* hdl/mandelbrot_escape_time_pixel_core.sv */
// Top level of the escape-time pixel core: registers, engine and divider chain.
//  channel | direction | handshake        | contents
//  s_*     | in        | s_tvalid/tready  | col, row
//  m_*     | out       | m_tvalid/tready  | iterations, escaped, gray
//  cfg_*   | in        | cfg_wen          | register index and data
// A pixel moves the engine from idle through setup, then a multiply and an add state
// per iteration, to a done state that waits for the chain; the next pixel is taken in idle.
// Each iteration is a multiply state, with three separate products, followed by an add state.
// The divider chain overlaps the next pixel.
// Reset restores the register defaults; a stalled output halts the chain.
`default_nettype none
`include "mandelbrot_escape_time_pixel_core_macros.svh"
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // col[11:0], row[23:12]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // iterations[7:0], escaped[8], gray[16:9], zero
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	logic signed [31:0] x_min_q, y_min_q, step_x_q, step_y_q;
	logic [7:0]         max_iter_q;
	logic               en;
	logic [7:0]         eng_iters;
	logic [7:0]         gray;
	div_word_t          chain [0:DIV_STAGES];
	div_word_t          tail;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q    <= X_MIN_RST;
			y_min_q    <= Y_MIN_RST;
			step_x_q   <= STEP_X_RST;
			step_y_q   <= STEP_Y_RST;
			max_iter_q <= MAX_IT_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_MIN:    x_min_q    <= cfg_wdata;
				REG_Y_MIN:    y_min_q    <= cfg_wdata;
				REG_STEP_X:   step_x_q   <= cfg_wdata;
				REG_STEP_Y:   step_y_q   <= cfg_wdata;
				REG_MAX_ITER: max_iter_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// The chain moves whenever its last word can leave.
	assign en = !chain[DIV_STAGES].valid || m_tready;

	mbe_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.col      (s_tdata[11:0]),
		.row      (s_tdata[23:12]),
		.x_min    (x_min_q),
		.y_min    (y_min_q),
		.step_x   (step_x_q),
		.step_y   (step_y_q),
		.max_iter (max_iter_q),
		.en       (en),
		.word     (chain[0]),
		.iters    (eng_iters)
	);

	// Divider chain, one quotient bit per cell.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		mbe_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	// Output word from the last cell.
	assign tail     = chain[DIV_STAGES];
	assign gray     = (chain[DIV_STAGES].div == 8'd0) ? 8'd0 : chain[DIV_STAGES].quo;
	assign m_tvalid = chain[DIV_STAGES].valid;
	assign m_tdata  = {7'b0, gray, chain[DIV_STAGES].esc, chain[DIV_STAGES].iters};

	`MBE_ASSERT_IMPL(a_it_bound, !s_tready, eng_iters <= max_iter_q, "count passed the limit")
	`MBE_ASSERT_IMPL(a_esc_below, m_tvalid && tail.esc, tail.iters < tail.div, "escaped at the limit")
	`MBE_ASSERT_IMPL(a_full_gray, m_tvalid && !tail.esc && tail.div != 8'd0, gray == 8'd255, "gray below full")
	`MBE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
endmodule
`default_nettype wire

/* hdl/mbe_div_cell.sv */
// One restoring-division cell of the gray-level divider chain.
`default_nettype none
module mbe_div_cell import mbe_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire div_word_t din,
	output div_word_t      dout
);
	logic [16:0] trial;
	logic        ge;
	logic [15:0] nrem;
	div_word_t   nxt;

	// Try to take the divisor scaled by 128, then shift the remainder up.
	always_comb begin
		trial = {1'b0, din.rem} - {2'b00, din.div, 7'b0};
		ge    = !trial[16];
		nrem  = ge ? trial[15:0] : din.rem;
		nxt   = din;
		nxt.rem = {nrem[14:0], 1'b0};
		nxt.quo = {din.quo[6:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

/* hdl/mbe_iter.sv */
// Coordinate setup and z = z^2 + c iteration engine.
`default_nettype none
module mbe_iter import mbe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [11:0]        col,
	input  wire logic [11:0]        row,
	input  wire logic signed [31:0] x_min,
	input  wire logic signed [31:0] y_min,
	input  wire logic signed [31:0] step_x,
	input  wire logic signed [31:0] step_y,
	input  wire logic [7:0]         max_iter,
	input  wire logic               en,
	output div_word_t               word,
	output logic [7:0]              iters
);
	typedef enum logic [2:0] {ST_IDLE, ST_SETUP, ST_MUL, ST_ADD, ST_DONE} state_t;

	state_t                 st_q;
	logic [COORD_USE-1:0]   col_q, row_q;
	logic signed [31:0]     cr_q, ci_q, zx_q, zy_q, p_q, zx2_q, zy2_q;
	logic [7:0]             it_q;
	logic signed [31:0]     cr_n, ci_n, mag, nx, ny;
	logic                   go;

	// Pixel coordinate: exact product plus edge, then saturation.
	always_comb begin
		cr_n = sat32(ext64(x_min) + $signed(64'(col_q)) * ext64(step_x));
		ci_n = sat32(ext64(y_min) + $signed(64'(row_q)) * ext64(step_y));
	end

	// Escape test and next z from the registered products.
	always_comb begin
		mag = sat32(ext64(zx2_q) + ext64(zy2_q));
		go  = (it_q < max_iter) && (mag < FOUR);
		ny  = sat32(ext64(sat32(ext64(p_q) + ext64(p_q))) + ext64(ci_q));
		nx  = sat32(ext64(sat32(ext64(zx2_q) - ext64(zy2_q))) + ext64(cr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			it_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						it_q <= '0;
						st_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					if (go) begin
						it_q <= it_q + 8'd1;
						st_q <= ST_MUL;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (en) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			col_q <= col[COORD_USE-1:0];
			row_q <= row[COORD_USE-1:0];
		end
		if (st_q == ST_SETUP) begin
			cr_q <= cr_n;
			ci_q <= ci_n;
			zx_q <= '0;
			zy_q <= '0;
		end
		if (st_q == ST_MUL) begin
			p_q   <= fx_mul(zx_q, zy_q);
			zx2_q <= fx_mul(zx_q, zx_q);
			zy2_q <= fx_mul(zy_q, zy_q);
		end
		if (st_q == ST_ADD && go) begin
			zx_q <= nx;
			zy_q <= ny;
		end
	end

	assign in_ready = (st_q == ST_IDLE);
	assign iters    = it_q;

	// Hand the count to the divider as it*255 over max_iter.
	always_comb begin
		word.valid = (st_q == ST_DONE);
		word.rem   = {it_q, 8'h00} - {8'h00, it_q};
		word.div   = max_iter;
		word.quo   = '0;
		word.iters = it_q;
		word.esc   = (it_q < max_iter);
	end
endmodule
`default_nettype wire
